// ===== design/mecanum_wheel_mixer_defines.svh =====
// Assertion macros used by the checker file of the wheel mixer.
`ifndef MECANUM_WHEEL_MIXER_DEFINES_SVH
`define MECANUM_WHEEL_MIXER_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define MWM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mecanum_wheel_mixer: check failed");

// Next-cycle implication, off while reset is high.
`define MWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mecanum_wheel_mixer: check failed");

// Next-cycle implication that also holds across reset.
`define MWM_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mecanum_wheel_mixer: check failed");

`endif

// ===== design/mwm_pkg.sv =====
package mwm_pkg;

  localparam int NUM_WHEELS = 4;
  localparam int IN_W       = 16;             // one chassis command field
  localparam int SUM_W      = 18;             // exact mixed wheel sum
  localparam int MAG_W      = 17;             // magnitude of a wheel sum
  localparam int LIM_W      = 15;             // wheel speed limit
  localparam int PROD_W     = MAG_W + LIM_W;  // magnitude times limit
  localparam int QUO_W      = LIM_W;          // quotient never exceeds the limit
  localparam int OUT_W      = 16;             // scaled wheel speed

  // Stages ahead of the divider: mix, magnitude, pair max, peak, multiply.
  localparam int PRE_STAGES = 5;
  localparam int NUM_STAGES = PRE_STAGES + QUO_W;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 15'd8000;

  // Wheel mixing signs: wheel 1 = x - y + r, 2 = x + y + r,
  // 3 = -x + y + r, 4 = -x - y + r (bit k is wheel k+1).
  localparam logic [NUM_WHEELS-1:0] X_NEG = 4'b1100;
  localparam logic [NUM_WHEELS-1:0] Y_NEG = 4'b1001;

  typedef struct packed {
    logic [NUM_WHEELS-1:0][SUM_W-1:0]  wheel;  // mixed sums, two's complement
    logic [NUM_WHEELS-1:0][MAG_W-1:0]  mag;
    logic [1:0][MAG_W-1:0]             pair;
    logic [MAG_W-1:0]                  peak;
    logic                              scale;
    logic [NUM_WHEELS-1:0][PROD_W-1:0] rem;
    logic [NUM_WHEELS-1:0][QUO_W-1:0]  quo;
  } mix_stage_t;

endpackage

// ===== design/mecanum_wheel_mixer.sv =====
// Mecanum wheel mixer: turns a chassis command (forward, sideways, rotation)
// into four wheel speeds and, when the largest wheel magnitude exceeds the
// configured limit, scales all four by limit / largest, truncated toward zero;
// tuser flags that scaling took place. One command is accepted per clock
// while the output is not stalled. Five stages mix, take magnitudes, find the
// peak and form magnitude times limit, then a restoring divider of fifteen
// stages resolves one quotient bit each, and a last stage restores the sign
// into the output register. Stalls from the output only stop stages that hold
// data, so empty slots are filled.
// Write the limit only while no command is in flight.
module mecanum_wheel_mixer
  import mwm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // [15:0] speed_x, [31:16] speed_y, [47:32] rotation
  input  logic [3*IN_W-1:0]          s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [15:0] wheel_one, [31:16] wheel_two, [47:32] wheel_three, [63:48] wheel_four
  output logic [NUM_WHEELS*OUT_W-1:0] m_tdata,
  // [0] was_scaled
  output logic                       m_tuser,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [LIM_W-1:0]           cfg_data
);

  logic [LIM_W-1:0]      limit;
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES:0]   adv;
  mix_stage_t            stage     [NUM_STAGES];
  mix_stage_t            stage_next[NUM_STAGES];
  logic [NUM_WHEELS*OUT_W-1:0] tdata_next;

  assign cfg_ready = 1'b1;
  assign s_tready  = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit <= cfg_data;
    end
  end

  // A stage may load when it is empty or its content moves on.
  always_comb begin
    adv[NUM_STAGES] = !m_tvalid || m_tready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  // Mix the three commands into four exact sums.
  always_comb begin
    logic signed [SUM_W-1:0] x, y, r, tx, ty;
    x = SUM_W'(signed'(s_tdata[IN_W-1:0]));
    y = SUM_W'(signed'(s_tdata[2*IN_W-1:IN_W]));
    r = SUM_W'(signed'(s_tdata[3*IN_W-1:2*IN_W]));
    stage_next[0] = '0;
    for (int k = 0; k < NUM_WHEELS; k++) begin
      tx = X_NEG[k] ? -x : x;
      ty = Y_NEG[k] ? -y : y;
      stage_next[0].wheel[k] = tx + ty + r;
    end
  end

  always_comb begin
    logic [SUM_W-1:0] neg;
    stage_next[1] = stage[0];
    for (int k = 0; k < NUM_WHEELS; k++) begin
      neg = -stage[0].wheel[k];
      stage_next[1].mag[k] = stage[0].wheel[k][SUM_W-1] ? neg[MAG_W-1:0]
                                                        : stage[0].wheel[k][MAG_W-1:0];
    end
  end

  always_comb begin
    stage_next[2] = stage[1];
    stage_next[2].pair[0] = (stage[1].mag[0] > stage[1].mag[1]) ? stage[1].mag[0]
                                                                : stage[1].mag[1];
    stage_next[2].pair[1] = (stage[1].mag[2] > stage[1].mag[3]) ? stage[1].mag[2]
                                                                : stage[1].mag[3];
  end

  always_comb begin
    stage_next[3] = stage[2];
    stage_next[3].peak = (stage[2].pair[0] > stage[2].pair[1]) ? stage[2].pair[0]
                                                               : stage[2].pair[1];
  end

  always_comb begin
    stage_next[4] = stage[3];
    stage_next[4].scale = stage[3].peak > MAG_W'(limit);
    for (int k = 0; k < NUM_WHEELS; k++) begin
      stage_next[4].rem[k] = PROD_W'(stage[3].mag[k]) * PROD_W'(limit);
      stage_next[4].quo[k] = '0;
    end
  end

  // Restoring divider: one quotient bit per stage, most significant first.
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    localparam int SI  = PRE_STAGES + j;
    localparam int BIT = QUO_W - 1 - j;
    always_comb begin
      logic [PROD_W:0] trial;
      stage_next[SI] = stage[SI-1];
      for (int k = 0; k < NUM_WHEELS; k++) begin
        trial = {1'b0, stage[SI-1].rem[k]} - ((PROD_W+1)'(stage[SI-1].peak) << BIT);
        if (!trial[PROD_W]) begin
          stage_next[SI].rem[k]      = trial[PROD_W-1:0];
          stage_next[SI].quo[k][BIT] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic [OUT_W-1:0] q;
    for (int k = 0; k < NUM_WHEELS; k++) begin
      q = OUT_W'(stage[NUM_STAGES-1].quo[k]);
      if (stage[NUM_STAGES-1].scale) begin
        tdata_next[k*OUT_W +: OUT_W] = stage[NUM_STAGES-1].wheel[k][SUM_W-1] ? -q : q;
      end else begin
        tdata_next[k*OUT_W +: OUT_W] = stage[NUM_STAGES-1].wheel[k][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
      if (adv[NUM_STAGES]) begin
        m_tvalid <= vld[NUM_STAGES-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (adv[i]) begin
        stage[i] <= stage_next[i];
      end
    end
    if (adv[NUM_STAGES]) begin
      m_tdata <= tdata_next;
      m_tuser <= stage[NUM_STAGES-1].scale;
    end
  end

endmodule

// ===== design/mwm_checker.sv =====
`include "mecanum_wheel_mixer_defines.svh"

module mwm_checker
  import mwm_pkg::*;
(
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [NUM_WHEELS*OUT_W-1:0] m_tdata,
  input logic                        m_tuser
);

  // A held transaction keeps its payload.
  `MWM_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // An empty output means the whole pipeline can take a command.
  `MWM_ASSERT_NOW(a_ready_when_empty, clk, rst, !m_tvalid, s_tready)

  // Wheel speeds stay within the limit range, so the most negative code never shows.
  `MWM_ASSERT_NOW(a_wheel_range, clk, rst, m_tvalid,
    (m_tdata[15:0] != 16'h8000) && (m_tdata[31:16] != 16'h8000) &&
    (m_tdata[47:32] != 16'h8000) && (m_tdata[63:48] != 16'h8000))

  // Reset drops any pending result.
  `MWM_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !m_tvalid)

endmodule

bind mecanum_wheel_mixer mwm_checker u_mwm_checker (.*);

// ===== test/mecanum_wheel_mixer_tb.sv =====
module mecanum_wheel_mixer_tb;
  import mwm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_SLACK = 2 * (NUM_STAGES + 1);

  typedef struct packed {
    logic [NUM_WHEELS*OUT_W-1:0] wheels;  // wheel_one in the low bits
    logic                        scaled;
  } wheel_result_t;

  typedef struct {
    logic [LIM_W-1:0]        limit;
    logic signed [IN_W-1:0]  x;
    logic signed [IN_W-1:0]  y;
    logic signed [IN_W-1:0]  r;
    bit                      known;
    wheel_result_t           result;
  } cmd_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [3*IN_W-1:0]           s_tdata = '0;  // [15:0] x, [31:16] y, [47:32] rotation
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [NUM_WHEELS*OUT_W-1:0] m_tdata;       // wheel_one .. wheel_four, 16 bits each
  logic                        m_tuser;       // [0] was_scaled
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [LIM_W-1:0]            cfg_data = '0;

  wheel_result_t    wheels_due[$];
  cmd_row_t         cmd_table[$];
  logic [LIM_W-1:0] limit_now = LIMIT_RESET;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int unsigned      mismatches = 0;
  int unsigned      cmds_sent = 0;
  int unsigned      results_seen = 0;
  int unsigned      scaled_seen = 0;
  int unsigned      limit_writes = 0;

  mecanum_wheel_mixer uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("timeout: %0d results still due", wheels_due.size());
    $display("== FAIL ==");
    $finish;
  end

  // Mix one chassis command and normalize against the limit.
  function automatic wheel_result_t mix_wheels(input logic signed [IN_W-1:0] x,
                                               input logic signed [IN_W-1:0] y,
                                               input logic signed [IN_W-1:0] r,
                                               input logic [LIM_W-1:0] lim);
    int            sum[NUM_WHEELS];
    int            peak;
    int            lim_i;
    int            mag;
    longint        q;
    wheel_result_t res;
    lim_i  = int'(lim);
    sum[0] = int'(x) - int'(y) + int'(r);
    sum[1] = int'(x) + int'(y) + int'(r);
    sum[2] = -int'(x) + int'(y) + int'(r);
    sum[3] = -int'(x) - int'(y) + int'(r);
    peak = 0;
    for (int k = 0; k < NUM_WHEELS; k++) begin
      mag = (sum[k] < 0) ? -sum[k] : sum[k];
      if (mag > peak) peak = mag;
    end
    res.scaled = (peak > lim_i);
    for (int k = 0; k < NUM_WHEELS; k++) begin
      q = longint'(sum[k]);
      if (res.scaled) q = (q * longint'(lim_i)) / longint'(peak);
      res.wheels[k*OUT_W +: OUT_W] = q[OUT_W-1:0];
    end
    return res;
  endfunction

  task automatic add_row(input logic [LIM_W-1:0] lim, input logic signed [IN_W-1:0] x,
                         input logic signed [IN_W-1:0] y, input logic signed [IN_W-1:0] r,
                         input bit known, input logic signed [OUT_W-1:0] w1,
                         input logic signed [OUT_W-1:0] w2, input logic signed [OUT_W-1:0] w3,
                         input logic signed [OUT_W-1:0] w4, input logic sc);
    cmd_row_t row;
    row.limit = lim;
    row.x = x;
    row.y = y;
    row.r = r;
    row.known = known;
    row.result.wheels = {w4, w3, w2, w1};
    row.result.scaled = sc;
    cmd_table.push_back(row);
  endtask

  // Hold the sender until every result is back and the pipe has emptied.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (wheels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIM_W-1:0] lim);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_now = lim;
    limit_writes++;
  endtask

  task automatic send_cmd(input logic signed [IN_W-1:0] x, input logic signed [IN_W-1:0] y,
                          input logic signed [IN_W-1:0] r, input bit known,
                          input wheel_result_t given);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r, y, x};
    do @(posedge clk); while (!s_tready);
    wheels_due.push_back(known ? given : mix_wheels(x, y, r, limit_now));
    cmds_sent++;
  endtask

  function automatic logic [LIM_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 15'h7FFF;
      2: return LIM_W'($urandom_range(1, 100));
      3: return LIMIT_RESET;
      default: return LIM_W'($urandom_range(0, 32767));
    endcase
  endfunction

  task automatic send_random_cmd();
    logic signed [IN_W-1:0] v[3];
    logic signed [IN_W-1:0] corner[5];
    int                     mode;
    int                     span;
    corner = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      if (mode <= 3) begin
        v[k] = IN_W'($urandom);
      end else if (mode <= 5) begin
        // stay near the limit so both sides of the threshold show up
        span = int'(limit_now) / 3 + 1;
        v[k] = IN_W'($urandom_range(0, 2 * span) - span);
      end else if (mode == 6) begin
        v[k] = corner[$urandom_range(0, 4)];
      end else begin
        v[k] = '0;
      end
    end
    if (mode >= 7) begin
      // one axis only, a few counts around the limit
      v[$urandom_range(0, 2)] = IN_W'((int'(limit_now) + $urandom_range(0, 4) - 2)
                                      * (($urandom_range(0, 1) != 0) ? -1 : 1));
    end
    send_cmd(v[0], v[1], v[2], 1'b0, '0);
  endtask

  // Output side: check each transaction, then pick the next ready.
  always @(posedge clk) begin : wheel_monitor
    wheel_result_t due;
    bit            bad;
    if (!rst && m_tvalid && m_tready) begin
      if (wheels_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result %h/%b", m_tdata, m_tuser);
        mismatches++;
      end else begin
        due = wheels_due.pop_front();
        bad = 1'b0;
        for (int k = 0; k < NUM_WHEELS; k++)
          if (m_tdata[k*OUT_W +: OUT_W] !== due.wheels[k*OUT_W +: OUT_W]) bad = 1'b1;
        if (m_tuser !== due.scaled) bad = 1'b1;
        if (bad) begin
          if (mismatches < 10)
            $display("result %0d: expected %h/%b, got %h/%b", results_seen,
                     due.wheels, due.scaled, m_tdata, m_tuser);
          mismatches++;
        end
        if (m_tuser === 1'b1) scaled_seen++;
        results_seen++;
      end
    end
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin : stimulus
    cmd_row_t row;
    int       idle_send[3];
    int       idle_recv[3];
    idle_send = '{34, 54, 0};
    idle_recv = '{54, 34, 0};

    //        limit  x        y        r        known w1      w2      w3      w4      sc
    add_row(8000,  0,       0,       0,       1, 0,      0,      0,      0,      0);
    add_row(8000,  1000,    0,       0,       1, 1000,   1000,   -1000,  -1000,  0);
    add_row(8000,  0,       1000,    0,       1, -1000,  1000,   1000,   -1000,  0);
    add_row(8000,  0,       0,       1000,    1, 1000,   1000,   1000,   1000,   0);
    add_row(8000,  8000,    0,       0,       1, 8000,   8000,   -8000,  -8000,  0);
    add_row(8000,  8001,    0,       0,       1, 8000,   8000,   -8000,  -8000,  1);
    add_row(8000,  32767,   32767,   32767,   0, 0,      0,      0,      0,      0);
    add_row(8000,  -32768,  -32768,  -32768,  0, 0,      0,      0,      0,      0);
    add_row(8000,  -32768,  32767,   -32768,  0, 0,      0,      0,      0,      0);
    add_row(8000,  32767,   -32768,  32767,   0, 0,      0,      0,      0,      0);
    add_row(8000,  1234,    -4321,   777,     0, 0,      0,      0,      0,      0);
    add_row(0,     0,       0,       0,       1, 0,      0,      0,      0,      0);
    add_row(0,     1,       0,       0,       1, 0,      0,      0,      0,      1);
    add_row(0,     -32768,  -32768,  -32768,  1, 0,      0,      0,      0,      1);
    add_row(32767, 10000,   -5000,   3000,    1, 18000,  8000,   -12000, -2000,  0);
    add_row(32767, -32768,  0,       0,       1, -32767, -32767, 32767,  32767,  1);
    add_row(32767, 32767,   32767,   32767,   0, 0,      0,      0,      0,      0);
    add_row(32767, -1,      -1,      -1,      0, 0,      0,      0,      0,      0);
    add_row(1,     3,       1,       0,       0, 0,      0,      0,      0,      0);
    add_row(1,     -1,      0,       0,       1, -1,     -1,     1,      1,      0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = idle_send[0];
    recv_idle_pct = idle_recv[0];
    foreach (cmd_table[i]) begin
      row = cmd_table[i];
      if (row.limit != limit_now) write_limit(row.limit);
      send_cmd(row.x, row.y, row.r, row.known, row.result);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = idle_send[phase];
      recv_idle_pct = idle_recv[phase];
      for (int chunk = 0; chunk < 5; chunk++) begin
        if (phase == 0 && chunk == 0) write_limit(15'h7FFF);
        else if (phase == 0 && chunk == 1) write_limit('0);
        else write_limit(pick_limit());
        for (int k = 0; k < 80; k++) begin
          if (phase == 1 && chunk == 2 && k == 40) drain_results();
          send_random_cmd();
        end
      end
    end

    drain_results();
    if (wheels_due.size() != 0) begin
      $display("%0d results never arrived", wheels_due.size());
      mismatches += wheels_due.size();
    end
    $display("ran %0d commands over %0d limit writes, %0d results checked (%0d scaled)",
             cmds_sent, limit_writes, results_seen, scaled_seen);
    $display("limits included 0 and 32767; idling on both sides, then none; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
